// File: design/ssc_pkg.sv
// shared types and constants for the symbol support counter
`timescale 1ns / 1ps
`default_nettype none

package ssc_pkg;

   localparam int SYMBOL_W = 32;
   localparam int COUNT_W  = 16;
   localparam int TALLY_W  = 6;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic REQ_COUNT = 1'b0;
   localparam logic REQ_DUMP  = 1'b1;

   localparam logic KIND_ENTRY   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef enum logic [1:0] {
      STATE_IDLE = 2'b01,
      STATE_DUMP = 2'b10
   } state_type;

   typedef struct packed {
      logic                count_en;
      logic                shift;
      logic [SYMBOL_W-1:0] symbol;
   } ctrl_type;

endpackage

`default_nettype wire

// File: design/ssc_cell.sv
// one table entry of the cell chain: compare, count, insert and shift
`timescale 1ns / 1ps
`default_nettype none

module ssc_cell (
   input  wire logic                         clock,
   input  wire ssc_pkg::ctrl_type            ctrl,
   input  wire logic                         active,
   input  wire logic                         insert,
   input  wire logic [ssc_pkg::SYMBOL_W-1:0] next_symbol,
   input  wire logic [ssc_pkg::COUNT_W-1:0]  next_count,
   output logic      [ssc_pkg::SYMBOL_W-1:0] symbol,
   output logic      [ssc_pkg::COUNT_W-1:0]  count,
   output logic                              hit
);
   import ssc_pkg::*;

   logic [SYMBOL_W-1:0] symbol_ff;
   logic [SYMBOL_W-1:0] symbol_in;
   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W-1:0]  count_in;

   assign hit    = ctrl.count_en && active && (symbol_ff == ctrl.symbol);
   assign symbol = symbol_ff;
   assign count  = count_ff;

   always_comb begin
      symbol_in = symbol_ff;
      count_in  = count_ff;
      if (ctrl.shift) begin
         symbol_in = next_symbol;
         count_in  = next_count;
      end else if (insert) begin
         symbol_in = ctrl.symbol;
         count_in  = COUNT_W'(1);
      end else if (hit && (count_ff != COUNT_MAX)) begin
         count_in = count_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      symbol_ff <= symbol_in;
      count_ff  <= count_in;
   end

endmodule

`default_nettype wire

// File: design/symbol_support_counter.sv
// top level: chain of counting cells with dump sequencer and result register
`timescale 1ns / 1ps
`default_nettype none

// A count request (req_type 0) is taken on start; busy stays low, so count requests
// may follow one another in every cycle and produce no result. A dump request (req_type 1)
// raises busy for the run: the cell chain shifts its contents one entry per cycle towards
// the head, the head entry is reported when its count reaches the support threshold, and a
// final summary transfer with rsp_last set closes the run and empties the table. Each result
// is shown for exactly one cycle with rsp_strobe high, starting the cycle after the entry
// leaves the head; the receiver cannot stall the block and must take every transfer as it
// comes. Write the threshold via csr_write_enable only while idle; the block does not check.
module symbol_support_counter #(
   parameter int TABLE_DEPTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_type,
   input  wire logic [ssc_pkg::SYMBOL_W-1:0]  req_symbol,
   output logic                               rsp_strobe,
   output logic                               rsp_kind,
   output logic      [ssc_pkg::SYMBOL_W-1:0]  rsp_symbol_res,
   output logic      [ssc_pkg::COUNT_W-1:0]   rsp_occurrences,
   output logic      [ssc_pkg::TALLY_W-1:0]   rsp_passed_count,
   output logic      [ssc_pkg::TALLY_W-1:0]   rsp_distinct_count,
   output logic                               rsp_overflow,
   output logic                               rsp_last,
   input  wire logic                          csr_write_enable,
   input  wire logic [ssc_pkg::COUNT_W-1:0]   csr_write_data
);
   import ssc_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    used_ff, used_in;
   logic [CNT_W-1:0]    remain_ff, remain_in;
   logic [CNT_W-1:0]    passed_ff, passed_in;
   logic                overflow_ff, overflow_in;
   logic [COUNT_W-1:0]  threshold_ff;

   logic                strobe_ff, strobe_in;
   logic                kind_ff, kind_in;
   logic [SYMBOL_W-1:0] symbol_res_ff, symbol_res_in;
   logic [COUNT_W-1:0]  occ_ff, occ_in;
   logic [TALLY_W-1:0]  passed_out_ff, passed_out_in;
   logic [TALLY_W-1:0]  distinct_ff, distinct_in;
   logic                ovf_out_ff, ovf_out_in;
   logic                last_ff, last_in;

   ctrl_type            ctrl;
   logic                count_en;
   logic                shift_en;
   logic                accept;
   logic                any_hit;
   logic [TABLE_DEPTH-1:0] hit;
   logic [TABLE_DEPTH-1:0] active;
   logic [TABLE_DEPTH-1:0] insert;
   logic [SYMBOL_W-1:0] cell_symbol [TABLE_DEPTH];
   logic [COUNT_W-1:0]  cell_count  [TABLE_DEPTH];

   assign busy   = (state_ff == STATE_DUMP);
   assign accept = start && !busy;
   assign any_hit = |hit;

   assign count_en = accept && (req_type == REQ_COUNT);
   assign shift_en = (state_ff == STATE_DUMP) && (remain_ff != '0);
   assign ctrl     = {count_en, shift_en, req_symbol};

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic [SYMBOL_W-1:0] nxt_symbol;
      logic [COUNT_W-1:0]  nxt_count;

      if (i == TABLE_DEPTH - 1) begin : g_tail
         assign nxt_symbol = cell_symbol[i];
         assign nxt_count  = cell_count[i];
      end else begin : g_link
         assign nxt_symbol = cell_symbol[i+1];
         assign nxt_count  = cell_count[i+1];
      end

      assign active[i] = (CNT_W'(i) < used_ff);
      assign insert[i] = ctrl.count_en && !any_hit && (used_ff == CNT_W'(i));

      ssc_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .active      (active[i]),
         .insert      (insert[i]),
         .next_symbol (nxt_symbol),
         .next_count  (nxt_count),
         .symbol      (cell_symbol[i]),
         .count       (cell_count[i]),
         .hit         (hit[i])
      );
   end

   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      remain_in     = remain_ff;
      passed_in     = passed_ff;
      overflow_in   = overflow_ff;

      strobe_in     = 1'b0;
      kind_in       = KIND_ENTRY;
      symbol_res_in = '0;
      occ_in        = '0;
      passed_out_in = '0;
      distinct_in   = '0;
      ovf_out_in    = 1'b0;
      last_in       = 1'b0;

      case (state_ff)
         STATE_IDLE: begin
            if (accept) begin
               if (req_type == REQ_DUMP) begin
                  state_in  = STATE_DUMP;
                  remain_in = used_ff;
                  passed_in = '0;
               end else if (!any_hit) begin
                  if (used_ff == CNT_W'(TABLE_DEPTH)) begin
                     overflow_in = 1'b1;
                  end else begin
                     used_in = used_ff + CNT_W'(1);
                  end
               end
            end
         end
         STATE_DUMP: begin
            if (remain_ff != '0) begin
               remain_in  = remain_ff - CNT_W'(1);
               if (cell_count[0] >= threshold_ff) begin
                  strobe_in     = 1'b1;
                  symbol_res_in = cell_symbol[0];
                  occ_in        = cell_count[0];
                  passed_in     = passed_ff + CNT_W'(1);
               end
            end else begin
               strobe_in     = 1'b1;
               kind_in       = KIND_SUMMARY;
               passed_out_in = TALLY_W'(passed_ff);
               distinct_in   = TALLY_W'(used_ff);
               ovf_out_in    = overflow_ff;
               last_in       = 1'b1;
               used_in       = '0;
               overflow_in   = 1'b0;
               state_in      = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         used_ff      <= '0;
         remain_ff    <= '0;
         passed_ff    <= '0;
         overflow_ff  <= 1'b0;
         threshold_ff <= COUNT_W'(1);
         strobe_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         used_ff     <= used_in;
         remain_ff   <= remain_in;
         passed_ff   <= passed_in;
         overflow_ff <= overflow_in;
         strobe_ff   <= strobe_in;
         if (csr_write_enable) begin
            threshold_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      symbol_res_ff <= symbol_res_in;
      occ_ff        <= occ_in;
      passed_out_ff <= passed_out_in;
      distinct_ff   <= distinct_in;
      ovf_out_ff    <= ovf_out_in;
      last_ff       <= last_in;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_symbol_res     = symbol_res_ff;
   assign rsp_occurrences    = occ_ff;
   assign rsp_passed_count   = passed_out_ff;
   assign rsp_distinct_count = distinct_ff;
   assign rsp_overflow       = ovf_out_ff;
   assign rsp_last           = last_ff;

endmodule

`default_nettype wire

// File: design/ssc_checker.sv
// port-level checks for the symbol support counter and their bind
`timescale 1ns / 1ps
`default_nettype none

module ssc_checker (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic busy,
   input  wire logic req_type,
   input  wire logic rsp_strobe,
   input  wire logic rsp_kind,
   input  wire logic rsp_last
);
   import ssc_pkg::*;

   // a dump transfer holds off further requests
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_type == REQ_DUMP) |=> busy)
      else $error("dump did not raise busy");

   // counting gives no result and keeps the block free
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_type == REQ_COUNT) |=> !busy && !rsp_strobe)
      else $error("count request produced a result or busy");

   // results only come out of a dump run
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result outside a dump run");

   // the run ends exactly with the summary transfer
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe && rsp_last && (rsp_kind == KIND_SUMMARY))
      else $error("dump ended without summary");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |-> !busy)
      else $error("busy after summary");

endmodule

bind symbol_support_counter ssc_checker u_ssc_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_type   (req_type),
   .rsp_strobe (rsp_strobe),
   .rsp_kind   (rsp_kind),
   .rsp_last   (rsp_last)
);

`default_nettype wire
